[src/sliding_window_hit_counter_macros.svh]
// Assertion macros shared by the sliding window hit counter RTL.
`ifndef SLIDING_WINDOW_HIT_COUNTER_MACROS_SVH
`define SLIDING_WINDOW_HIT_COUNTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWHC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SWHC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/swhc_pkg.sv]
// Types and constants of the sliding window hit counter.
package swhc_pkg;

  localparam int unsigned TS_W  = 31;
  localparam int unsigned CNT_W = 32;

  localparam logic OP_HIT   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic             valid;
    logic [TS_W-1:0]  stamp;
    logic [CNT_W-1:0] hits;
  } bucket_t;

endpackage

[src/swhc_cell.sv]
// One bucket of the rotating ring: holds a bucket and passes it on when shifting.
module swhc_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  swhc_pkg::bucket_t bucket_i,
  output swhc_pkg::bucket_t bucket_o
);
  import swhc_pkg::*;

  logic             valid_q, valid_d;
  logic [TS_W-1:0]  stamp_q, stamp_d;
  logic [CNT_W-1:0] hits_q, hits_d;

  always_comb begin
    valid_d = valid_q;
    stamp_d = stamp_q;
    hits_d  = hits_q;
    if (shift_i) begin
      valid_d = bucket_i.valid;
      stamp_d = bucket_i.stamp;
      hits_d  = bucket_i.hits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stamp_q <= stamp_d;
    hits_q  <= hits_d;
  end

  assign bucket_o.valid = valid_q;
  assign bucket_o.stamp = stamp_q;
  assign bucket_o.hits  = hits_q;

endmodule

[src/swhc_mod.sv]
// Slot unit: timestamp modulo the window length by reciprocal multiplication, in three steps.
module swhc_mod #(
  parameter int unsigned WINDOW = 300,
  parameter int unsigned SLOT_W = $clog2(WINDOW)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [swhc_pkg::TS_W-1:0] dividend_i,
  output logic                      done_o,
  output logic [SLOT_W-1:0]         rem_o
);
  import swhc_pkg::*;

  // floor(n * RECIP / 2^SHIFT) equals floor(n / WINDOW) for every 31-bit stamp
  localparam int unsigned SHIFT  = TS_W + $clog2(WINDOW);
  localparam int unsigned PROD_W = TS_W + CNT_W;
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [CNT_W-1:0] RECIP   = RECIP_WIDE[CNT_W-1:0];
  localparam logic [TS_W-1:0]  DIVISOR = TS_W'(WINDOW);

  logic              s1_q;
  logic              s2_q;
  logic              done_q;
  logic [TS_W-1:0]   dvd_q, dvd_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [SLOT_W-1:0] rem_q, rem_d;
  logic [TS_W-1:0]   quot;
  logic [TS_W-1:0]   back;
  logic [TS_W-1:0]   rem_full;

  // hold the dividend until the remainder is out
  assign dvd_d    = start_i ? dividend_i : dvd_q;
  assign prod_d   = {{CNT_W{1'b0}}, dvd_q} * {{TS_W{1'b0}}, RECIP};
  assign quot     = TS_W'(prod_q[PROD_W-1:SHIFT]);
  assign back     = quot * DIVISOR;
  assign rem_full = dvd_q - back;
  assign rem_d    = rem_full[SLOT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= start_i;
      s2_q   <= s1_q;
      done_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[src/sliding_window_hit_counter.sv]
// Sliding window hit counter: a ring of WINDOW bucket cells rotated past one update point.
// Query: one full ring rotation, then a done state registers the result; the next item is
// taken back in idle. Hit: no result; slot remainder, then one full ring rotation.
// One item at a time; the time taken is set by the full ring rotation, one bucket a cycle,
// plus the slot remainder for a hit; an untaken result holds the next query.
// Reset clears every bucket valid bit at once; no clearing pass is needed.
`include "sliding_window_hit_counter_macros.svh"

module sliding_window_hit_counter #(
  parameter int unsigned WINDOW = 300
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       operation_i,
  input  logic [swhc_pkg::TS_W-1:0]  timestamp_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [swhc_pkg::CNT_W-1:0] hit_total_o
);
  import swhc_pkg::*;

  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
  localparam logic [TS_W-1:0]   SPAN      = TS_W'(WINDOW);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MOD  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic              op_q, op_d;
  logic [TS_W-1:0]   ts_q, ts_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SLOT_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0]  sum_q, sum_d;
  logic              out_valid_q, out_valid_d;
  logic [CNT_W-1:0]  total_q, total_d;

  logic              in_accept;
  logic              shift;
  logic              mod_start;
  logic              mod_done;
  logic [SLOT_W-1:0] mod_rem;

  bucket_t           ring [WINDOW];
  bucket_t           head;
  bucket_t           head_next;
  logic [TS_W-1:0]   age;
  logic [CNT_W:0]    sum_add;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign mod_start  = in_accept && (operation_i == OP_HIT);
  assign shift      = (state_q == ST_SCAN);

  swhc_mod #(
    .WINDOW (WINDOW),
    .SLOT_W (SLOT_W)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (timestamp_i),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // cell i takes from cell i+1; the last cell takes the updated head
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    bucket_t feed;
    if (i == WINDOW - 1) begin : g_tail
      assign feed = head_next;
    end else begin : g_mid
      assign feed = ring[i+1];
    end
    swhc_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (shift),
      .bucket_i (feed),
      .bucket_o (ring[i])
    );
  end

  assign head    = ring[0];
  assign age     = ts_q - head.stamp;
  assign sum_add = {1'b0, sum_q} + {1'b0, head.hits};

  // A hit updates the head bucket, a query sums or drops it; pos_q is its slot number.
  always_comb begin
    head_next = head;
    sum_d     = sum_q;
    if (op_q == OP_HIT) begin
      if (pos_q == slot_q) begin
        if (head.valid && (head.stamp == ts_q)) begin
          if (head.hits != CNT_MAX) begin
            head_next.hits = head.hits + 1'b1;
          end
        end else begin
          head_next.valid = 1'b1;
          head_next.stamp = ts_q;
          head_next.hits  = CNT_W'(1);
        end
      end
    end else if (head.valid && (head.stamp <= ts_q)) begin
      if (age >= SPAN) begin
        head_next.valid = 1'b0;   // drop expired bucket
      end else begin
        sum_d = sum_add[CNT_W] ? CNT_MAX : sum_add[CNT_W-1:0];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    ts_d        = ts_q;
    slot_d      = slot_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    total_d     = total_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          op_d  = operation_i;
          ts_d  = timestamp_i;
          pos_d = '0;
          state_d = (operation_i == OP_HIT) ? ST_MOD : ST_SCAN;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          slot_d  = mod_rem;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        pos_d = pos_q + 1'b1;
        if (pos_q == LAST_SLOT) begin
          pos_d   = '0;
          state_d = (op_q == OP_QUERY) ? ST_DONE : ST_IDLE;
        end
      end
      ST_DONE: begin
        // hold the sum until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          total_d     = sum_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    ts_q    <= ts_d;
    slot_q  <= slot_d;
    total_q <= total_d;
    if (state_q == ST_IDLE) begin
      sum_q <= '0;
    end else if (shift) begin
      sum_q <= sum_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_total_o = total_q;

  `SWHC_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_accept, state_q != ST_IDLE, "accepted item left block idle")
  `SWHC_ASSERT_NXT(a_scan_ends, clk_i, rst_ni, (state_q == ST_SCAN) && (pos_q == LAST_SLOT), (state_q != ST_SCAN) && (pos_q == '0), "ring rotation did not end after one full turn")
  `SWHC_ASSERT_NXT(a_mod_to_scan, clk_i, rst_ni, (state_q == ST_MOD) && mod_done, state_q == ST_SCAN, "slot remainder done but scan not started")
  `SWHC_ASSERT_IMP(a_result_from_query, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == ST_DONE) && (op_q == OP_QUERY), "result raised without a finished query")

endmodule
